FILE: design/tkri_pkg.sv
// shared types and constants for the ranked record table
package tkri_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned GRP_W      = 3;
  localparam int unsigned GRP        = 2 ** GRP_W;
  localparam int unsigned GSEL_W     = IDX_W - GRP_W;
  localparam int unsigned NUM_GROUPS = (DEPTH + GRP - 1) / GRP;
  localparam int unsigned MAX_GROUPS = 2 ** GSEL_W;
  localparam int unsigned RD_GROUPS  = (NUM_GROUPS < MAX_GROUPS) ? NUM_GROUPS : MAX_GROUPS;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [63:0] name_head;
    logic [31:0] name_tail;
    logic [30:0] visits;
    logic [30:0] stay_time;
  } rec_t;

  typedef struct packed {
    logic beats;
    rec_t rec;
  } link_t;

endpackage

FILE: design/top_k_ranked_insert.sv
// top level of the ranked record table: chain of slot cells plus read select
// an insert can be accepted every cycle unless a read holds in_stall_o; all
// slots compare in parallel and those the new record beats shift down one
// cell in the same cycle; a read passes the group select register, then the
// output register; the next transaction is taken once the read leaves the
// select stage; reset clears every slot at once
module top_k_ranked_insert (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [63:0] name_head_i,
  input  logic [31:0] name_tail_i,
  input  logic [30:0] visits_i,
  input  logic [30:0] stay_time_i,
  input  logic [5:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        slot_valid_o,
  output logic [63:0] out_name_head_o,
  output logic [31:0] out_name_tail_o,
  output logic [30:0] out_visits_o,
  output logic [30:0] out_stay_time_o
);
  import tkri_pkg::*;

  logic  accept;
  logic  ins_en;
  logic  rd_start;
  logic  rd_busy;
  rec_t  new_rec;
  rec_t  out_rec;
  link_t link [DEPTH+1];
  rec_t  cells [DEPTH];

  assign in_stall_o = rd_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign ins_en     = accept && (kind_e'(kind_i) == KIND_INSERT);
  assign rd_start   = accept && (kind_e'(kind_i) == KIND_READ);

  assign new_rec.name_head = name_head_i;
  assign new_rec.name_tail = name_tail_i;
  assign new_rec.visits    = visits_i;
  assign new_rec.stay_time = stay_time_i;

  assign link[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tkri_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ins_en_i  (ins_en),
      .new_rec_i (new_rec),
      .link_i    (link[i]),
      .link_o    (link[i+1])
    );
    assign cells[i] = link[i+1].rec;
  end

  tkri_read_sel u_read_sel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (rd_start),
    .idx_i        (slot_index_i),
    .cells_i      (cells),
    .busy_o       (rd_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slot_valid_o (slot_valid_o),
    .out_rec_o    (out_rec)
  );

  assign out_name_head_o = out_rec.name_head;
  assign out_name_tail_o = out_rec.name_tail;
  assign out_visits_o    = out_rec.visits;
  assign out_stay_time_o = out_rec.stay_time;

endmodule

FILE: design/tkri_cell.sv
// one ranked slot: compares against the new record and shifts from its neighbor
module tkri_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           ins_en_i,
  input  tkri_pkg::rec_t new_rec_i,
  input  tkri_pkg::link_t link_i,
  output tkri_pkg::link_t link_o
);
  import tkri_pkg::*;

  rec_t rec_q, rec_d;
  logic beats;

  assign beats = (new_rec_i.visits > rec_q.visits) ||
                 ((new_rec_i.visits == rec_q.visits) &&
                  (new_rec_i.stay_time > rec_q.stay_time));

  always_comb begin
    rec_d = rec_q;
    if (ins_en_i && beats) begin
      rec_d = link_i.beats ? link_i.rec : new_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign link_o.beats = beats;
  assign link_o.rec   = rec_q;

  // table stays sorted, so beating the slot above implies beating this one
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_i.beats |-> beats) else $error("ranking order broken");

  a_take_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ins_en_i && beats && !link_i.beats) |=> (rec_q == $past(new_rec_i)))
    else $error("insert slot did not take new record");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_en_i && beats) |=> $stable(rec_q)) else $error("slot changed without insert");

endmodule

FILE: design/tkri_read_sel.sv
// two-stage registered slot select for reads: group select register, then output register
module tkri_read_sel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tkri_pkg::IDX_W-1:0] idx_i,
  input  tkri_pkg::rec_t            cells_i [tkri_pkg::DEPTH],
  output logic                      busy_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      slot_valid_o,
  output tkri_pkg::rec_t            out_rec_o
);
  import tkri_pkg::*;

  rec_t              cand [RD_GROUPS][GRP];
  rec_t              grp_rec_d [RD_GROUPS];
  rec_t              grp_rec_q [RD_GROUPS];
  logic              s1_valid_q, s1_valid_d;
  logic [GSEL_W-1:0] s1_grp_q;
  logic              s1_inr_q;
  logic              s1_adv;
  logic              in_range;
  rec_t              sel;
  logic              out_valid_q, out_valid_d;
  rec_t              out_rec_q;

  for (genvar g = 0; g < RD_GROUPS; g++) begin : g_grp
    for (genvar k = 0; k < GRP; k++) begin : g_ent
      if (g * GRP + k < DEPTH) begin : g_live
        assign cand[g][k] = cells_i[g * GRP + k];
      end else begin : g_pad
        assign cand[g][k] = '0;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < RD_GROUPS; g++) begin
      grp_rec_d[g] = cand[g][idx_i[GRP_W-1:0]];
    end
  end

  assign in_range = 32'(idx_i) < 32'(DEPTH);
  assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (start_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    sel = '0;
    for (int g = 0; g < RD_GROUPS; g++) begin
      if (s1_grp_q == GSEL_W'(g)) begin
        sel = grp_rec_q[g];
      end
    end
    if (!s1_inr_q) begin
      sel = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      grp_rec_q <= grp_rec_d;
      s1_grp_q  <= idx_i[IDX_W-1:GRP_W];
      s1_inr_q  <= in_range;
    end
    if (s1_adv) begin
      out_rec_q <= sel;
    end
  end

  assign busy_o       = s1_valid_q;
  assign out_valid_o  = out_valid_q;
  assign out_rec_o    = out_rec_q;
  assign slot_valid_o = (out_rec_q.visits != '0);

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !s1_valid_q) else $error("read started while select stage full");

  a_start_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> s1_valid_q) else $error("select stage not filled");

  a_adv_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q) else $error("read result lost");

endmodule
